FILE: rtl/rpa_pkg.sv
// ---------------------------------------------------------------------------
// rpa_pkg: shared types and constants of the page allocator
// Field widths, operation and status codes, controller states and the
// command and status groups between the controller and the datapath.
// ---------------------------------------------------------------------------
package rpa_pkg;

  // Fixed field widths.
  localparam int ADDR_W     = 56;
  localparam int KIND_W     = 3;
  localparam int STATUS_W   = 2;
  localparam int CNT_OUT_W  = 8;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 56;

  // Reset value of both address registers.
  localparam logic [ADDR_W-1:0] CFG_RESET = 56'h00_0000_8000_0000;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_MEMORY_BASE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FREE_BOUND  = 1'b1;

  // Operation codes. Codes above reduce are unknown and do nothing.
  typedef enum logic [KIND_W-1:0] {
    KIND_INIT   = 3'd0,
    KIND_ALLOC  = 3'd1,
    KIND_FREE   = 3'd2,
    KIND_ADD    = 3'd3,
    KIND_REDUCE = 3'd4
  } kind_t;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_BAD_ADDR  = 2'd2,
    ST_COUNT_ERR = 2'd3
  } status_t;

  // Controller states.
  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_DISPATCH,
    S_INIT_A,
    S_INIT_B,
    S_INIT_WALK,
    S_POP,
    S_POP_DONE,
    S_CNT_RD,
    S_CNT_DONE,
    S_FINISH
  } state_t;

  // Which result the datapath builds when it emits a word.
  typedef enum logic [1:0] {
    RES_PLAIN,
    RES_ALLOC,
    RES_COUNT
  } res_sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     latch;
    logic     check;
    logic     clr_step;
    logic     init_a;
    logic     init_b;
    logic     init_step;
    logic     pop_read;
    logic     cnt_read;
    logic     emit;
    res_sel_t res_sel;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    kind_t kind;
    logic  addr_bad;
    logic  stack_empty;
    logic  clear_last;
    logic  walk_done;
    logic  out_busy;
  } sts_t;

endpackage

FILE: rtl/rpa_if.sv
// ---------------------------------------------------------------------------
// rpa_if: request and response channels of the page allocator
// Each channel carries valid, ready and the payload of one word.
// ---------------------------------------------------------------------------
interface rpa_req_if;
  logic                            valid;
  logic                            ready;
  logic [rpa_pkg::KIND_W-1:0]      kind;
  logic [rpa_pkg::ADDR_W-1:0]      page_addr;

  modport source (output valid, output kind, output page_addr, input ready);
  modport sink   (input valid, input kind, input page_addr, output ready);
endinterface

interface rpa_rsp_if;
  logic                            valid;
  logic                            ready;
  logic [rpa_pkg::ADDR_W-1:0]      result_addr;
  logic [rpa_pkg::STATUS_W-1:0]    status;
  logic [rpa_pkg::CNT_OUT_W-1:0]   count_after;

  modport source (output valid, output result_addr, output status, output count_after,
                  input ready);
  modport sink   (input valid, input result_addr, input status, input count_after,
                  output ready);
endinterface

FILE: rtl/rpa_ctrl.sv
// ---------------------------------------------------------------------------
// rpa_ctrl: operation sequencer of the page allocator
// Steps each accepted word through check, memory access and result emit,
// and runs the count clearing pass after reset and the init walk.
// ---------------------------------------------------------------------------
module rpa_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  rpa_pkg::sts_t sts,
  output rpa_pkg::cmd_t cmd
);

  rpa_pkg::state_t state;
  rpa_pkg::state_t state_next;

  // State register; reset starts the count clearing pass.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rpa_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      rpa_pkg::S_CLEAR: begin
        if (sts.clear_last) state_next = rpa_pkg::S_IDLE;
      end
      rpa_pkg::S_IDLE: begin
        if (req_valid) state_next = rpa_pkg::S_CHECK;
      end
      rpa_pkg::S_CHECK: begin
        state_next = rpa_pkg::S_DISPATCH;
      end
      rpa_pkg::S_DISPATCH: begin
        case (sts.kind)
          rpa_pkg::KIND_INIT: begin
            state_next = rpa_pkg::S_INIT_A;
          end
          rpa_pkg::KIND_ALLOC: begin
            state_next = sts.stack_empty ? rpa_pkg::S_FINISH : rpa_pkg::S_POP;
          end
          rpa_pkg::KIND_FREE, rpa_pkg::KIND_ADD, rpa_pkg::KIND_REDUCE: begin
            state_next = sts.addr_bad ? rpa_pkg::S_FINISH : rpa_pkg::S_CNT_RD;
          end
          default: begin
            state_next = rpa_pkg::S_FINISH;
          end
        endcase
      end
      rpa_pkg::S_INIT_A: begin
        state_next = rpa_pkg::S_INIT_B;
      end
      rpa_pkg::S_INIT_B: begin
        state_next = rpa_pkg::S_INIT_WALK;
      end
      rpa_pkg::S_INIT_WALK: begin
        if (sts.walk_done) state_next = rpa_pkg::S_FINISH;
      end
      rpa_pkg::S_POP: begin
        state_next = rpa_pkg::S_POP_DONE;
      end
      rpa_pkg::S_CNT_RD: begin
        state_next = rpa_pkg::S_CNT_DONE;
      end
      rpa_pkg::S_POP_DONE, rpa_pkg::S_CNT_DONE, rpa_pkg::S_FINISH: begin
        if (!sts.out_busy) state_next = rpa_pkg::S_IDLE;
      end
      default: begin
        state_next = rpa_pkg::S_IDLE;
      end
    endcase
  end

  // Command outputs.
  always_comb begin
    cmd         = '0;
    cmd.res_sel = rpa_pkg::RES_PLAIN;
    req_ready   = 1'b0;
    case (state)
      rpa_pkg::S_CLEAR: begin
        cmd.clr_step = 1'b1;
      end
      rpa_pkg::S_IDLE: begin
        req_ready = 1'b1;
        cmd.latch = req_valid;
      end
      rpa_pkg::S_CHECK: begin
        cmd.check = 1'b1;
      end
      rpa_pkg::S_INIT_A: begin
        cmd.init_a = 1'b1;
      end
      rpa_pkg::S_INIT_B: begin
        cmd.init_b = 1'b1;
      end
      rpa_pkg::S_INIT_WALK: begin
        cmd.init_step = 1'b1;
      end
      rpa_pkg::S_POP: begin
        cmd.pop_read = 1'b1;
      end
      rpa_pkg::S_CNT_RD: begin
        cmd.cnt_read = 1'b1;
      end
      rpa_pkg::S_POP_DONE: begin
        cmd.emit    = !sts.out_busy;
        cmd.res_sel = rpa_pkg::RES_ALLOC;
      end
      rpa_pkg::S_CNT_DONE: begin
        cmd.emit    = !sts.out_busy;
        cmd.res_sel = rpa_pkg::RES_COUNT;
      end
      rpa_pkg::S_FINISH: begin
        cmd.emit    = !sts.out_busy;
        cmd.res_sel = rpa_pkg::RES_PLAIN;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

FILE: rtl/rpa_dp.sv
// ---------------------------------------------------------------------------
// rpa_dp: datapath of the page allocator
// Holds the address registers, the free stack and count memories, the stack
// pointer, the address checks, the count update and the output register.
// ---------------------------------------------------------------------------
module rpa_dp #(
  parameter int NUM_PAGES   = 32768,
  parameter int PAGE_SHIFT  = 12,
  parameter int COUNT_WIDTH = 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  rpa_pkg::cmd_t                     cmd,
  output rpa_pkg::sts_t                     sts,
  input  logic [rpa_pkg::KIND_W-1:0]        req_kind,
  input  logic [rpa_pkg::ADDR_W-1:0]        req_page_addr,
  input  logic                              cfg_we,
  input  logic [rpa_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rpa_pkg::CFG_DATA_W-1:0]    cfg_data,
  output logic                              rsp_valid,
  input  logic                              rsp_ready,
  output logic [rpa_pkg::ADDR_W-1:0]        rsp_result_addr,
  output logic [rpa_pkg::STATUS_W-1:0]      rsp_status,
  output logic [rpa_pkg::CNT_OUT_W-1:0]     rsp_count_after
);

  localparam int AW    = rpa_pkg::ADDR_W;
  localparam int EXT_W = AW + 2;
  localparam int IDX_W = $clog2(NUM_PAGES);
  localparam int TOP_W = $clog2(NUM_PAGES + 1);

  localparam logic [IDX_W-1:0]       LAST_IDX  = IDX_W'(NUM_PAGES - 1);
  localparam logic [TOP_W-1:0]       TOP_FULL  = TOP_W'(NUM_PAGES);
  localparam logic [EXT_W-1:0]       SPAN      = EXT_W'(NUM_PAGES) << PAGE_SHIFT;
  localparam logic [EXT_W-1:0]       PAGE_LOW  = {{(EXT_W-PAGE_SHIFT){1'b0}},
                                                  {PAGE_SHIFT{1'b1}}};
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};
  localparam logic [COUNT_WIDTH-1:0] COUNT_ONE = COUNT_WIDTH'(1);

  // Memories.
  logic [IDX_W-1:0]       free_stack  [NUM_PAGES];
  logic [COUNT_WIDTH-1:0] page_counts [NUM_PAGES];

  // Configuration and derived bounds.
  logic [AW-1:0]    memory_base;
  logic [AW-1:0]    free_bound;
  logic [AW-1:0]    base_al;
  logic [EXT_W-1:0] base_ext;
  logic [EXT_W-1:0] top_addr;

  // Operation registers.
  rpa_pkg::kind_t   op_kind;
  logic [AW-1:0]    op_pa;
  logic             addr_bad;
  logic [IDX_W-1:0] op_idx;
  logic [EXT_W-1:0] p_round;
  logic [EXT_W-1:0] p_start;
  logic             init_empty;
  logic [IDX_W-1:0] walk_idx;
  logic [IDX_W-1:0] clr_idx;
  logic [TOP_W-1:0] free_top;
  logic [TOP_W-1:0] top_m1;
  logic [IDX_W-1:0] stack_rd;
  logic [COUNT_WIDTH-1:0] cnt_rd;

  // Check logic.
  logic             chk_aligned;
  logic             chk_ge_base;
  logic             chk_lt_top;
  logic             chk_ge_bound;
  logic [AW-1:0]    pa_off;
  logic [EXT_W-1:0] round_sum;
  logic [EXT_W-1:0] start_off;

  // Result logic.
  logic [COUNT_WIDTH-1:0] cnt_new;
  logic                   cnt_err;
  logic                   do_push;
  logic [AW-1:0]          alloc_addr;
  logic [AW-1:0]          res_addr;
  rpa_pkg::status_t       res_status;
  logic [rpa_pkg::CNT_OUT_W-1:0] res_cnt;

  // Memory write ports.
  logic                   cnt_we;
  logic [IDX_W-1:0]       cnt_waddr;
  logic [COUNT_WIDTH-1:0] cnt_wdata;
  logic                   stk_we;
  logic [IDX_W-1:0]       stk_wdata;

  assign base_al  = {memory_base[AW-1:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}};
  assign base_ext = {2'b00, base_al};
  assign top_m1   = free_top - TOP_W'(1);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      memory_base <= rpa_pkg::CFG_RESET;
      free_bound  <= rpa_pkg::CFG_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        rpa_pkg::CFG_MEMORY_BASE: memory_base <= cfg_data;
        rpa_pkg::CFG_FREE_BOUND:  free_bound  <= cfg_data;
        default: ;
      endcase
    end
  end

  // End of managed memory, registered from the base register.
  always_ff @(posedge clk) begin
    top_addr <= base_ext + SPAN;
  end

  // Address checks on the latched word.
  assign chk_aligned  = (op_pa[PAGE_SHIFT-1:0] == '0);
  assign chk_ge_base  = (op_pa >= base_al);
  assign chk_lt_top   = ({2'b00, op_pa} < top_addr);
  assign chk_ge_bound = (op_pa >= free_bound);
  assign pa_off       = op_pa - base_al;
  assign round_sum    = {2'b00, free_bound} + PAGE_LOW;
  assign start_off    = p_start - base_ext;

  // Word capture, checks and init setup.
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_kind <= rpa_pkg::kind_t'(req_kind);
      op_pa   <= req_page_addr;
    end
    if (cmd.check) begin
      addr_bad <= !chk_aligned || !chk_ge_base || !chk_lt_top ||
                  ((op_kind == rpa_pkg::KIND_FREE) && !chk_ge_bound);
      op_idx   <= pa_off[PAGE_SHIFT +: IDX_W];
      p_round  <= {round_sum[EXT_W-1:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}};
    end
    if (cmd.init_a) begin
      p_start <= (p_round < base_ext) ? base_ext : p_round;
    end
    if (cmd.init_b) begin
      init_empty <= (p_start >= top_addr);
      walk_idx   <= start_off[PAGE_SHIFT +: IDX_W];
    end else if (cmd.init_step) begin
      walk_idx <= walk_idx + IDX_W'(1);
    end
  end

  // Clearing pass counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx <= '0;
    end else if (cmd.clr_step) begin
      clr_idx <= clr_idx + IDX_W'(1);
    end
  end

  // Count update of free, add and reduce.
  always_comb begin
    cnt_new = cnt_rd;
    cnt_err = 1'b0;
    do_push = 1'b0;
    if (op_kind == rpa_pkg::KIND_ADD) begin
      if (cnt_rd == COUNT_MAX) cnt_err = 1'b1;
      else cnt_new = cnt_rd + COUNT_ONE;
    end else if (cnt_rd == '0) begin
      cnt_err = 1'b1;
    end else if ((op_kind == rpa_pkg::KIND_FREE) && (cnt_rd == COUNT_ONE)) begin
      cnt_new = '0;
      do_push = (free_top < TOP_FULL);
    end else begin
      cnt_new = cnt_rd - COUNT_ONE;
    end
  end

  assign alloc_addr = base_al + (AW'(stack_rd) << PAGE_SHIFT);

  // Result word selection.
  always_comb begin
    res_addr   = '0;
    res_status = rpa_pkg::ST_OK;
    res_cnt    = '0;
    case (cmd.res_sel)
      rpa_pkg::RES_ALLOC: begin
        res_addr = alloc_addr;
        res_cnt  = rpa_pkg::CNT_OUT_W'(COUNT_ONE);
      end
      rpa_pkg::RES_COUNT: begin
        res_status = cnt_err ? rpa_pkg::ST_COUNT_ERR : rpa_pkg::ST_OK;
        res_cnt    = rpa_pkg::CNT_OUT_W'(cnt_new);
      end
      default: begin
        if (op_kind == rpa_pkg::KIND_ALLOC) begin
          res_status = rpa_pkg::ST_EMPTY;
        end else if (op_kind inside {rpa_pkg::KIND_FREE, rpa_pkg::KIND_ADD,
                                     rpa_pkg::KIND_REDUCE}) begin
          res_status = rpa_pkg::ST_BAD_ADDR;
        end
      end
    endcase
  end

  // Count memory write port.
  always_comb begin
    cnt_we    = 1'b0;
    cnt_waddr = clr_idx;
    cnt_wdata = '0;
    if (cmd.clr_step) begin
      cnt_we = 1'b1;
    end else if (cmd.init_step) begin
      cnt_we    = !init_empty;
      cnt_waddr = walk_idx;
    end else if (cmd.emit && (cmd.res_sel == rpa_pkg::RES_ALLOC)) begin
      cnt_we    = 1'b1;
      cnt_waddr = stack_rd;
      cnt_wdata = COUNT_ONE;
    end else if (cmd.emit && (cmd.res_sel == rpa_pkg::RES_COUNT)) begin
      cnt_we    = 1'b1;
      cnt_waddr = op_idx;
      cnt_wdata = cnt_new;
    end
  end

  // Stack write port: init walk pushes and free pushes.
  always_comb begin
    stk_we    = 1'b0;
    stk_wdata = walk_idx;
    if (cmd.init_step) begin
      stk_we = !init_empty;
    end else if (cmd.emit && (cmd.res_sel == rpa_pkg::RES_COUNT)) begin
      stk_we    = do_push;
      stk_wdata = op_idx;
    end
  end

  // Count memory.
  always_ff @(posedge clk) begin
    if (cnt_we) page_counts[cnt_waddr] <= cnt_wdata;
    if (cmd.cnt_read) cnt_rd <= page_counts[op_idx];
  end

  // Free stack memory.
  always_ff @(posedge clk) begin
    if (stk_we) free_stack[free_top[IDX_W-1:0]] <= stk_wdata;
    if (cmd.pop_read) stack_rd <= free_stack[top_m1[IDX_W-1:0]];
  end

  // Stack pointer.
  always_ff @(posedge clk) begin
    if (rst) begin
      free_top <= '0;
    end else if (cmd.init_b) begin
      free_top <= '0;
    end else if (stk_we) begin
      free_top <= free_top + TOP_W'(1);
    end else if (cmd.pop_read) begin
      free_top <= top_m1;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.emit) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      rsp_result_addr <= res_addr;
      rsp_status      <= res_status;
      rsp_count_after <= res_cnt;
    end
  end

  // Status to the controller.
  assign sts.kind        = op_kind;
  assign sts.addr_bad    = addr_bad;
  assign sts.stack_empty = (free_top == '0);
  assign sts.clear_last  = (clr_idx == LAST_IDX);
  assign sts.walk_done   = init_empty || (walk_idx == LAST_IDX);
  assign sts.out_busy    = rsp_valid && !rsp_ready;

endmodule

FILE: rtl/refcounted_page_allocator.sv
// ---------------------------------------------------------------------------
// refcounted_page_allocator: page frame allocator with reference counts
// Keeps free page frames on a stack and a reference count for every frame.
// ---------------------------------------------------------------------------
// Usage:
//   req carries one word per operation (kind, page_addr); rsp returns one
//   word per request (result_addr, status, count_after). cfg_we, cfg_index
//   and cfg_data write memory_base (index 0) and free_bound (index 1); write
//   them only while no request is in flight.
//   A request is taken only when the sequencer is idle. Alloc, free, add and
//   reduce run from acceptance to the next acceptance through capture,
//   address check, dispatch, one memory read (stack or count memory), and
//   the emit step that writes back and loads the output register. Unknown
//   kinds and rejected requests skip the memory read. Init runs capture,
//   check, dispatch and init setup, then walks the pages, one stack push and
//   count write per cycle; an init with no page still visits the walk state.
//   After reset the count memory is cleared, one entry a cycle, over all
//   NUM_PAGES entries; req.ready stays low during that pass.
//   The response sits in an output register, so a new request is taken while
//   an earlier response waits. If the receiver stalls with a response still
//   held, the next operation waits in its emit cycle until the register frees.
// ---------------------------------------------------------------------------
module refcounted_page_allocator #(
  parameter int NUM_PAGES   = 32768,
  parameter int PAGE_SHIFT  = 12,
  parameter int COUNT_WIDTH = 8
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [rpa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rpa_pkg::CFG_DATA_W-1:0] cfg_data,
  rpa_req_if.sink                        req,
  rpa_rsp_if.source                      rsp
);

  rpa_pkg::cmd_t cmd;
  rpa_pkg::sts_t sts;

  // Sequencer.
  rpa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Datapath with memories and output register.
  rpa_dp #(
    .NUM_PAGES   (NUM_PAGES),
    .PAGE_SHIFT  (PAGE_SHIFT),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .req_kind        (req.kind),
    .req_page_addr   (req.page_addr),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_result_addr (rsp.result_addr),
    .rsp_status      (rsp.status),
    .rsp_count_after (rsp.count_after)
  );

endmodule

FILE: test/tb_refcounted_page_allocator.sv
// ---------------------------------------------------------------------------
// tb_refcounted_page_allocator: self-checking bench for the page allocator
// Drives request words with bursty timing against a stalling receiver and
// checks every result word against an in-bench model of the free stack and
// the per-page reference counts. Phases with different base and bound
// settings run back to back, with the block drained before each change.
// ---------------------------------------------------------------------------
module tb_refcounted_page_allocator;

  localparam int NUM_PAGES   = 32768;
  localparam int PAGE_SHIFT  = 12;
  localparam int COUNT_WIDTH = 8;

  localparam logic [63:0] PAGE_BYTES64 = 64'd1 << PAGE_SHIFT;
  localparam logic [63:0] PAGE_MASK64  = PAGE_BYTES64 - 64'd1;
  localparam int unsigned REF_MAX      = (1 << COUNT_WIDTH) - 1;

  // Operation codes that the block does not know.
  localparam logic [rpa_pkg::KIND_W-1:0] KIND_SPARE_FIRST = 3'd5;
  localparam logic [rpa_pkg::KIND_W-1:0] KIND_SPARE_LAST  = 3'd7;

  // Cycles without any accepted word or returned result before the run is declared hung.
  localparam int WATCHDOG_LIMIT = 200000;

  typedef struct packed {
    logic [rpa_pkg::KIND_W-1:0] kind;
    logic [rpa_pkg::ADDR_W-1:0] page_addr;
  } page_op_t;

  typedef struct packed {
    logic [rpa_pkg::ADDR_W-1:0]    result_addr;
    logic [rpa_pkg::STATUS_W-1:0]  status;
    logic [rpa_pkg::CNT_OUT_W-1:0] count_after;
  } page_rsp_t;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_BURSTY
  } rx_mode_t;

  logic                           clk;
  logic                           rst;
  logic                           cfg_we;
  logic [rpa_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [rpa_pkg::CFG_DATA_W-1:0] cfg_data;

  rpa_req_if req_bus ();
  rpa_rsp_if rsp_bus ();

  refcounted_page_allocator #(
    .NUM_PAGES  (NUM_PAGES),
    .PAGE_SHIFT (PAGE_SHIFT),
    .COUNT_WIDTH(COUNT_WIDTH)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .req      (req_bus),
    .rsp      (rsp_bus)
  );

  // Shadow copy of the registers and of the allocator state.
  logic [rpa_pkg::ADDR_W-1:0] shadow_base;
  logic [rpa_pkg::ADDR_W-1:0] shadow_bound;
  int unsigned                free_frames [NUM_PAGES];
  int unsigned                free_depth;
  logic [COUNT_WIDTH-1:0]     frame_refs [NUM_PAGES];

  page_op_t  op_backlog [$];
  page_rsp_t pending_results [$];
  int        items_queued;
  int        words_accepted;
  int        error_count;
  int        quiet_cycles;
  bit        word_taken;

  // Sender and receiver pacing.
  int       burst_left;
  int       gap_left;
  rx_mode_t rx_mode;
  int       mode_left;
  int       stall_left;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic void push_frame(int unsigned idx);
    if (free_depth < NUM_PAGES) begin
      free_frames[free_depth] = idx;
      free_depth++;
    end
  endfunction

  // Applies one operation to the shadow state and returns its result word.
  function automatic page_rsp_t predict_page_op(logic [rpa_pkg::KIND_W-1:0] k,
                                                logic [rpa_pkg::ADDR_W-1:0] pa);
    page_rsp_t   r;
    logic [63:0] base;
    logic [63:0] top;
    logic [63:0] p;
    logic [63:0] pa64;
    int unsigned idx;
    int unsigned c;
    r    = '0;
    base = {8'h00, shadow_base} & ~PAGE_MASK64;
    top  = base + (64'(NUM_PAGES) << PAGE_SHIFT);
    pa64 = {8'h00, pa};
    case (k)
      rpa_pkg::KIND_INIT: begin
        p = ({8'h00, shadow_bound} + PAGE_MASK64) & ~PAGE_MASK64;
        if (p < base) p = base;
        free_depth = 0;
        while (p + PAGE_BYTES64 <= top) begin
          idx = int'((p - base) >> PAGE_SHIFT);
          frame_refs[idx] = '0;
          push_frame(idx);
          p += PAGE_BYTES64;
        end
      end
      rpa_pkg::KIND_ALLOC: begin
        if (free_depth == 0) begin
          r.status = rpa_pkg::ST_EMPTY;
        end else begin
          free_depth--;
          idx = free_frames[free_depth] % NUM_PAGES;
          frame_refs[idx] = COUNT_WIDTH'(1);
          r.result_addr = rpa_pkg::ADDR_W'(base + (64'(idx) << PAGE_SHIFT));
          r.count_after = 8'd1;
        end
      end
      rpa_pkg::KIND_FREE, rpa_pkg::KIND_ADD, rpa_pkg::KIND_REDUCE: begin
        if ((pa64 & PAGE_MASK64) != 0 || pa64 < base || pa64 >= top ||
            (k == rpa_pkg::KIND_FREE && pa < shadow_bound)) begin
          r.status = rpa_pkg::ST_BAD_ADDR;
        end else begin
          idx = int'((pa64 - base) >> PAGE_SHIFT);
          c   = 32'(frame_refs[idx]);
          if (k == rpa_pkg::KIND_ADD) begin
            if (c >= REF_MAX) r.status = rpa_pkg::ST_COUNT_ERR;
            else c++;
          end else if (c == 0) begin
            r.status = rpa_pkg::ST_COUNT_ERR;
          end else if (k == rpa_pkg::KIND_FREE && c == 1) begin
            c = 0;
            push_frame(idx);
          end else begin
            c--;
          end
          frame_refs[idx] = c[COUNT_WIDTH-1:0];
          r.count_after   = c[rpa_pkg::CNT_OUT_W-1:0];
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Request acceptance, result checking and the watchdog, all on the rising edge.
  always @(posedge clk) begin
    page_rsp_t want;
    if (rst) begin
      word_taken   = 1'b0;
      quiet_cycles = 0;
    end else begin
      word_taken = req_bus.valid && req_bus.ready;
      if (word_taken) begin
        pending_results.push_back(predict_page_op(req_bus.kind, req_bus.page_addr));
        words_accepted++;
      end
      if (rsp_bus.valid && rsp_bus.ready) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result word: result_addr %h status %0d count_after %0d",
                 rsp_bus.result_addr, rsp_bus.status, rsp_bus.count_after);
          error_count++;
        end else begin
          want = pending_results.pop_front();
          if (rsp_bus.result_addr !== want.result_addr) begin
            $error("result_addr: expected %h, got %h", want.result_addr, rsp_bus.result_addr);
            error_count++;
          end
          if (rsp_bus.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, rsp_bus.status);
            error_count++;
          end
          if (rsp_bus.count_after !== want.count_after) begin
            $error("count_after: expected %0d, got %0d",
                   want.count_after, rsp_bus.count_after);
            error_count++;
          end
        end
      end
      if (word_taken || (rsp_bus.valid && rsp_bus.ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // Request driver: bursts of words separated by random gaps.
  always @(negedge clk) begin
    page_op_t op;
    if (rst) begin
      req_bus.valid <= 1'b0;
    end else if (req_bus.valid && !word_taken) begin
      // The current word is still waiting for ready.
    end else if (gap_left > 0) begin
      gap_left--;
      req_bus.valid <= 1'b0;
    end else if (op_backlog.size() > 0) begin
      op = op_backlog.pop_front();
      req_bus.valid     <= 1'b1;
      req_bus.kind      <= op.kind;
      req_bus.page_addr <= op.page_addr;
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      end
    end else begin
      req_bus.valid <= 1'b0;
    end
  end

  // Result receiver: switches between open, coin-flip and bursty stalling.
  always @(negedge clk) begin
    logic next_ready;
    if (rst) begin
      next_ready = 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode   = rx_mode_t'($urandom_range(0, 2));
        mode_left = $urandom_range(50, 300);
      end
      mode_left--;
      case (rx_mode)
        RX_OPEN: next_ready = 1'b1;
        RX_COIN: next_ready = 1'($urandom_range(0, 1));
        default: begin
          if (stall_left > 0) begin
            stall_left--;
            next_ready = 1'b0;
          end else if ($urandom_range(0, 19) == 0) begin
            stall_left = $urandom_range(1, 25);
            next_ready = 1'b0;
          end else begin
            next_ready = 1'b1;
          end
        end
      endcase
    end
    rsp_bus.ready <= next_ready;
  end

  function automatic logic [rpa_pkg::ADDR_W-1:0] page_at(int idx);
    return rpa_pkg::ADDR_W'(({8'h00, shadow_base} & ~PAGE_MASK64) +
                            (64'(idx) << PAGE_SHIFT));
  endfunction

  task automatic queue_op(logic [rpa_pkg::KIND_W-1:0] k, logic [rpa_pkg::ADDR_W-1:0] a);
    op_backlog.push_back('{kind: k, page_addr: a});
    items_queued++;
  endtask

  // Waits until every queued word is taken and every result has come back.
  task automatic wait_all_results();
    while (!(words_accepted == items_queued && pending_results.size() == 0))
      @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(logic [rpa_pkg::CFG_IDX_W-1:0] idx,
                           logic [rpa_pkg::ADDR_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    if (idx == rpa_pkg::CFG_MEMORY_BASE) shadow_base = value;
    else shadow_bound = value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Sets the base and a free bound that leaves only the top few pages to walk.
  task automatic set_window(logic [rpa_pkg::ADDR_W-1:0] base_raw, int walk);
    logic [63:0] aligned;
    logic [63:0] bound;
    aligned = {8'h00, base_raw} & ~PAGE_MASK64;
    bound   = aligned + (64'(NUM_PAGES - walk) << PAGE_SHIFT)
              - 64'($urandom_range(0, int'(PAGE_MASK64)));
    write_reg(rpa_pkg::CFG_MEMORY_BASE, base_raw);
    write_reg(rpa_pkg::CFG_FREE_BOUND, bound[rpa_pkg::ADDR_W-1:0]);
  endtask

  // Mostly well-formed traffic on the pages near the top, with some noise.
  task automatic run_phase(int n_items, int walk, bit allow_init, bit hammer);
    int                         lo;
    int                         pick;
    int                         roll;
    logic [rpa_pkg::KIND_W-1:0] k;
    logic [rpa_pkg::ADDR_W-1:0] a;
    lo = NUM_PAGES - walk - 2;
    if (lo < 0) lo = 0;
    for (int i = 0; i < n_items; i++) begin
      // Drive one page up past the count limit and back down a little.
      if (hammer && i == n_items / 2) begin
        pick = $urandom_range(lo, NUM_PAGES - 1);
        repeat (REF_MAX + 2) queue_op(rpa_pkg::KIND_ADD, page_at(pick));
        repeat (3) queue_op(rpa_pkg::KIND_REDUCE, page_at(pick));
      end
      roll = $urandom_range(0, 99);
      pick = $urandom_range(lo, NUM_PAGES - 1);
      a    = page_at(pick);
      if (roll < 30) begin
        k = rpa_pkg::KIND_ALLOC;
      end else if (roll < 52) begin
        k = rpa_pkg::KIND_FREE;
      end else if (roll < 70) begin
        k = rpa_pkg::KIND_ADD;
      end else if (roll < 85) begin
        k = rpa_pkg::KIND_REDUCE;
      end else if (roll < 87) begin
        k = allow_init ? rpa_pkg::KIND_INIT : rpa_pkg::KIND_ALLOC;
      end else begin
        k = rpa_pkg::KIND_W'(rpa_pkg::KIND_FREE) + rpa_pkg::KIND_W'($urandom_range(0, 2));
        case ($urandom_range(0, 4))
          0: begin
            k = rpa_pkg::KIND_W'($urandom_range(rpa_pkg::KIND_ALLOC, KIND_SPARE_LAST));
            a = rpa_pkg::ADDR_W'({$urandom, $urandom});
          end
          1: a = a + rpa_pkg::ADDR_W'($urandom_range(1, int'(PAGE_MASK64)));
          2: a = $urandom_range(0, 1) ? page_at(-1) : page_at(NUM_PAGES);
          3: begin
            k = rpa_pkg::KIND_W'($urandom_range(KIND_SPARE_FIRST, KIND_SPARE_LAST));
            a = rpa_pkg::ADDR_W'({$urandom, $urandom});
          end
          default: begin
            k = rpa_pkg::KIND_FREE;
            a = page_at($urandom_range(0, lo));
          end
        endcase
      end
      queue_op(k, a);
    end
  endtask

  initial begin
    logic [rpa_pkg::ADDR_W-1:0] base_raw;
    rst            = 1'b1;
    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    req_bus.valid  = 1'b0;
    req_bus.kind   = '0;
    req_bus.page_addr = '0;
    rsp_bus.ready  = 1'b0;
    shadow_base    = rpa_pkg::CFG_RESET;
    shadow_bound   = rpa_pkg::CFG_RESET;
    free_depth     = 0;
    foreach (frame_refs[i]) frame_refs[i] = '0;
    items_queued   = 0;
    words_accepted = 0;
    error_count    = 0;
    burst_left     = 0;
    gap_left       = 0;
    mode_left      = 0;
    stall_left     = 0;
    rx_mode        = RX_OPEN;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset settings: empty stack, count limits and address checks.
    queue_op(rpa_pkg::KIND_ALLOC, '0);
    queue_op(rpa_pkg::KIND_ADD, page_at(0));
    queue_op(rpa_pkg::KIND_REDUCE, page_at(0));
    queue_op(rpa_pkg::KIND_REDUCE, page_at(0));
    queue_op(rpa_pkg::KIND_FREE, page_at(0));
    queue_op(KIND_SPARE_FIRST, '0);
    queue_op(KIND_SPARE_LAST, '1);
    queue_op(rpa_pkg::KIND_FREE, page_at(0) + rpa_pkg::ADDR_W'(1));
    queue_op(rpa_pkg::KIND_ADD, page_at(-1));
    queue_op(rpa_pkg::KIND_ADD, page_at(NUM_PAGES));
    queue_op(rpa_pkg::KIND_ADD, page_at(NUM_PAGES - 1));
    wait_all_results();

    // Four walked pages: drain the stack, free below the bound, recycle a page.
    set_window(rpa_pkg::CFG_RESET, 4);
    queue_op(rpa_pkg::KIND_INIT, '0);
    repeat (5) queue_op(rpa_pkg::KIND_ALLOC, '0);
    queue_op(rpa_pkg::KIND_FREE, page_at(0));
    queue_op(rpa_pkg::KIND_FREE, page_at(NUM_PAGES - 1));
    queue_op(rpa_pkg::KIND_ALLOC, '0);
    queue_op(rpa_pkg::KIND_ADD, page_at(NUM_PAGES - 1));
    queue_op(rpa_pkg::KIND_FREE, page_at(NUM_PAGES - 1));
    queue_op(rpa_pkg::KIND_REDUCE, page_at(NUM_PAGES - 1));
    queue_op(rpa_pkg::KIND_REDUCE, page_at(NUM_PAGES - 1));
    wait_all_results();

    // Zero base and bound: a full walk, then a free while the stack is full.
    write_reg(rpa_pkg::CFG_MEMORY_BASE, '0);
    write_reg(rpa_pkg::CFG_FREE_BOUND, '0);
    queue_op(rpa_pkg::KIND_INIT, '0);
    queue_op(rpa_pkg::KIND_ADD, page_at(5));
    queue_op(rpa_pkg::KIND_FREE, page_at(5));
    queue_op(rpa_pkg::KIND_ALLOC, '0);
    wait_all_results();

    // Random phases over several base settings with short walks.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: base_raw = '0;
        1: base_raw = rpa_pkg::CFG_RESET;
        default: begin
          base_raw = rpa_pkg::ADDR_W'({$urandom, $urandom});
          base_raw[rpa_pkg::ADDR_W-1] = 1'b0;
        end
      endcase
      set_window(base_raw, $urandom_range(1, 48));
      queue_op(rpa_pkg::KIND_INIT, '0);
      run_phase(175, NUM_PAGES - int'((shadow_bound - page_at(0) +
                                       rpa_pkg::ADDR_W'(PAGE_MASK64)) >> PAGE_SHIFT),
                1'b1, ph == 1 || ph == 5);
      wait_all_results();
    end

    // Largest base and bound: the walk runs past the top of the address space.
    write_reg(rpa_pkg::CFG_MEMORY_BASE, '1);
    write_reg(rpa_pkg::CFG_FREE_BOUND, '1);
    queue_op(rpa_pkg::KIND_INIT, '0);
    run_phase(100, 8, 1'b0, 1'b0);
    wait_all_results();

    repeat (40) @(negedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/rpa_pkg.sv
rtl/rpa_if.sv
rtl/rpa_ctrl.sv
rtl/rpa_dp.sv
rtl/refcounted_page_allocator.sv
test/tb_refcounted_page_allocator.sv
